/* sv/csb_pkg.sv */
// Shared types, codes and defaults for the counting semaphore bank.
package csb_pkg;

   localparam int DEF_NUM_SEMAPHORES = 16;
   localparam int DEF_WAIT_DEPTH     = 8;
   localparam int DEF_THREAD_ID_BITS = 8;

   localparam logic [2:0] CMD_INIT     = 3'd0;
   localparam logic [2:0] CMD_WAIT     = 3'd1;
   localparam logic [2:0] CMD_POST     = 3'd2;
   localparam logic [2:0] CMD_TRYWAIT  = 3'd3;
   localparam logic [2:0] CMD_GETVALUE = 3'd4;
   localparam logic [2:0] CMD_RELEASE  = 3'd5;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_BLOCKED     = 3'd1;
   localparam logic [2:0] ST_WOULD_BLOCK = 3'd2;
   localparam logic [2:0] ST_INVALID     = 3'd3;
   localparam logic [2:0] ST_QFULL       = 3'd4;
   localparam logic [2:0] ST_SATURATED   = 3'd5;

   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      OP_INIT,
      OP_WAIT,
      OP_POST,
      OP_TRYWAIT,
      OP_GETVALUE,
      OP_RELEASE,
      OP_REJECT
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [3:0]  sem_index;
      logic [7:0]  caller_id;
      logic [15:0] init_value;
   } item_type;

endpackage

/* sv/csb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module csb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                    wr_data,
   input  logic                                rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                    rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/csb_front.sv */
// Front end: accepts request transactions, classifies them, queues them for the back end.
module csb_front #(
   parameter int NUM_SEMAPHORES = csb_pkg::DEF_NUM_SEMAPHORES
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_command,
   input  logic [3:0]        req_sem_index,
   input  logic [7:0]        req_caller_id,
   input  logic [15:0]       req_init_value,
   output logic              q_valid,
   output csb_pkg::item_type q_item,
   input  logic              q_pop
);

   localparam int QDEPTH = 2;

   csb_pkg::item_type entry_ff [QDEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   csb_pkg::item_type new_item;
   logic              push;
   logic              pop;

   always_comb begin
      new_item.sem_index  = req_sem_index;
      new_item.caller_id  = req_caller_id;
      new_item.init_value = req_init_value;
      unique case (req_command)
         csb_pkg::CMD_INIT:     new_item.op = csb_pkg::OP_INIT;
         csb_pkg::CMD_WAIT:     new_item.op = csb_pkg::OP_WAIT;
         csb_pkg::CMD_POST:     new_item.op = csb_pkg::OP_POST;
         csb_pkg::CMD_TRYWAIT:  new_item.op = csb_pkg::OP_TRYWAIT;
         csb_pkg::CMD_GETVALUE: new_item.op = csb_pkg::OP_GETVALUE;
         csb_pkg::CMD_RELEASE:  new_item.op = csb_pkg::OP_RELEASE;
         default:               new_item.op = csb_pkg::OP_REJECT;
      endcase
      // out-of-range slot is rejected regardless of command
      if (32'(req_sem_index) >= NUM_SEMAPHORES) begin
         new_item.op = csb_pkg::OP_REJECT;
      end
   end

   assign req_stall = (fill_ff == 2'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

/* sv/csb_back.sv */
// Back end: executes queued commands against the slot state and waiter RAM.
module csb_back #(
   parameter int NUM_SEMAPHORES = csb_pkg::DEF_NUM_SEMAPHORES,
   parameter int WAIT_DEPTH     = csb_pkg::DEF_WAIT_DEPTH,
   parameter int THREAD_ID_BITS = csb_pkg::DEF_THREAD_ID_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  csb_pkg::item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [15:0]       rsp_count_value,
   output logic              rsp_woken_valid,
   output logic [7:0]        rsp_woken_thread
);

   localparam int SB    = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
   localparam int QB    = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
   localparam int FB    = $clog2(WAIT_DEPTH + 1);
   localparam int TB    = THREAD_ID_BITS;
   localparam int DEPTH = NUM_SEMAPHORES * (1 << QB);
   localparam int AB    = SB + QB;

   typedef enum logic [1:0] {
      BK_EXEC = 2'b01,
      BK_WAKE = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;

   logic          valid_ff [NUM_SEMAPHORES];
   logic [15:0]   count_ff [NUM_SEMAPHORES];
   logic [QB-1:0] head_ff  [NUM_SEMAPHORES];
   logic [FB-1:0] fill_ff  [NUM_SEMAPHORES];

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff;
   logic [15:0]   rsp_count_ff;
   logic          rsp_woken_valid_ff;
   logic [7:0]    rsp_woken_thread_ff;
   logic [2:0]    pend_status_ff;
   logic [15:0]   pend_count_ff;

   logic [SB-1:0] s;
   logic          cur_valid;
   logic [15:0]   cur_cnt;
   logic [QB-1:0] cur_head;
   logic [FB-1:0] cur_fill;
   logic          valid_in;
   logic [15:0]   cnt_in;
   logic [QB-1:0] head_in;
   logic [FB-1:0] fill_in;
   logic          upd;
   logic          out_free;
   logic          exec;
   logic          go_wake;
   logic          load_res;
   logic [2:0]    res_status;
   logic [15:0]   res_count;
   logic [QB+1:0] tail_sum;
   logic [QB-1:0] tail;
   logic [QB-1:0] head_next;
   logic          wr_en;
   logic          rd_en;
   logic [AB-1:0] wr_addr;
   logic [AB-1:0] rd_addr;
   logic [TB-1:0] wr_data;
   logic [TB-1:0] rd_data;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign exec     = (state_ff == BK_EXEC) && q_valid && out_free;
   assign q_pop    = exec;

   assign s         = SB'(q_item.sem_index);
   assign cur_valid = valid_ff[s];
   assign cur_cnt   = count_ff[s];
   assign cur_head  = head_ff[s];
   assign cur_fill  = fill_ff[s];

   always_comb begin
      tail_sum = (QB+2)'(cur_head) + (QB+2)'(cur_fill);
      if (tail_sum >= (QB+2)'(WAIT_DEPTH)) begin
         tail_sum = tail_sum - (QB+2)'(WAIT_DEPTH);
      end
      tail      = QB'(tail_sum);
      head_next = (cur_head == QB'(WAIT_DEPTH - 1)) ? '0 : cur_head + QB'(1);
   end

   assign wr_addr = {s, tail};
   assign rd_addr = {s, cur_head};
   assign wr_data = TB'(q_item.caller_id);

   always_comb begin
      upd        = 1'b0;
      valid_in   = cur_valid;
      cnt_in     = cur_cnt;
      head_in    = cur_head;
      fill_in    = cur_fill;
      wr_en      = 1'b0;
      rd_en      = 1'b0;
      go_wake    = 1'b0;
      res_status = csb_pkg::ST_INVALID;
      res_count  = '0;
      if (exec && q_item.op != csb_pkg::OP_REJECT &&
          (q_item.op == csb_pkg::OP_INIT || cur_valid)) begin
         upd        = 1'b1;
         res_status = csb_pkg::ST_OK;
         unique case (q_item.op)
            csb_pkg::OP_INIT: begin
               valid_in = 1'b1;
               cnt_in   = q_item.init_value;
               head_in  = '0;
               fill_in  = '0;
            end
            csb_pkg::OP_WAIT: begin
               if (cur_cnt != 16'd0) begin
                  cnt_in = cur_cnt - 16'd1;
               end else if (cur_fill == FB'(WAIT_DEPTH)) begin
                  res_status = csb_pkg::ST_QFULL;
               end else begin
                  wr_en      = 1'b1;
                  fill_in    = cur_fill + FB'(1);
                  res_status = csb_pkg::ST_BLOCKED;
               end
            end
            csb_pkg::OP_POST: begin
               if (cur_cnt == csb_pkg::COUNT_MAX) begin
                  res_status = csb_pkg::ST_SATURATED;
               end else begin
                  cnt_in = cur_cnt + 16'd1;
               end
               if (cur_fill != '0) begin
                  rd_en   = 1'b1;
                  go_wake = 1'b1;
                  head_in = head_next;
                  fill_in = cur_fill - FB'(1);
               end
            end
            csb_pkg::OP_TRYWAIT: begin
               if (cur_cnt == 16'd0) begin
                  res_status = csb_pkg::ST_WOULD_BLOCK;
               end else begin
                  cnt_in = cur_cnt - 16'd1;
               end
            end
            csb_pkg::OP_RELEASE: begin
               valid_in = 1'b0;
               cnt_in   = '0;
               head_in  = '0;
               fill_in  = '0;
            end
            default: begin
            end
         endcase
         res_count = cnt_in;
      end
   end

   // waiter id comes back from the registered RAM read in the cycle after a post
   assign load_res = (exec && !go_wake) || (state_ff == BK_WAKE);

   always_comb begin
      unique case (state_ff)
         BK_EXEC: state_in = go_wake ? BK_WAKE : BK_EXEC;
         BK_WAKE: state_in = BK_EXEC;
         default: state_in = BK_EXEC;
      endcase
      if (load_res) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_EXEC;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_SEMAPHORES; i++) begin
            valid_ff[i] <= 1'b0;
            count_ff[i] <= '0;
            head_ff[i]  <= '0;
            fill_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (upd) begin
            valid_ff[s] <= valid_in;
            count_ff[s] <= cnt_in;
            head_ff[s]  <= head_in;
            fill_ff[s]  <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go_wake) begin
         pend_status_ff <= res_status;
         pend_count_ff  <= res_count;
      end
      if (state_ff == BK_WAKE) begin
         rsp_status_ff       <= pend_status_ff;
         rsp_count_ff        <= pend_count_ff;
         rsp_woken_valid_ff  <= 1'b1;
         rsp_woken_thread_ff <= 8'(rd_data);
      end else if (load_res) begin
         rsp_status_ff       <= res_status;
         rsp_count_ff        <= res_count;
         rsp_woken_valid_ff  <= 1'b0;
         rsp_woken_thread_ff <= '0;
      end
   end

   csb_ram #(
      .WIDTH (TB),
      .DEPTH (DEPTH)
   ) u_waiters (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_count_value  = rsp_count_ff;
   assign rsp_woken_valid  = rsp_woken_valid_ff;
   assign rsp_woken_thread = rsp_woken_thread_ff;

endmodule

/* sv/counting_semaphore_bank.sv */
// Top level of the counting semaphore bank: front end, command queue, back end.
// rsp_valid is registered in the back end, behind the command queue; a post that wakes
// a waiter also passes through the registered waiter RAM read before it responds.
// Throughput: one transaction per cycle unless stalled; a waking post adds BK_WAKE.
// Reset (synchronous): all slots invalid with zero count and empty wait queue;
// the waiter RAM is not cleared, entries are only read after being written.
module counting_semaphore_bank #(
   parameter int NUM_SEMAPHORES = csb_pkg::DEF_NUM_SEMAPHORES,
   parameter int WAIT_DEPTH     = csb_pkg::DEF_WAIT_DEPTH,
   parameter int THREAD_ID_BITS = csb_pkg::DEF_THREAD_ID_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [3:0]  req_sem_index,
   input  logic [7:0]  req_caller_id,
   input  logic [15:0] req_init_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_count_value,
   output logic        rsp_woken_valid,
   output logic [7:0]  rsp_woken_thread
);

   logic              q_valid;
   logic              q_pop;
   csb_pkg::item_type q_item;

   csb_front #(
      .NUM_SEMAPHORES (NUM_SEMAPHORES)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_sem_index  (req_sem_index),
      .req_caller_id  (req_caller_id),
      .req_init_value (req_init_value),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   csb_back #(
      .NUM_SEMAPHORES (NUM_SEMAPHORES),
      .WAIT_DEPTH     (WAIT_DEPTH),
      .THREAD_ID_BITS (THREAD_ID_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_count_value  (rsp_count_value),
      .rsp_woken_valid  (rsp_woken_valid),
      .rsp_woken_thread (rsp_woken_thread)
   );

endmodule

/* tb/tb_counting_semaphore_bank.sv */
// Self-checking testbench for counting_semaphore_bank: directed and random command traffic.
module tb_counting_semaphore_bank;

   localparam int SEM_SLOTS  = csb_pkg::DEF_NUM_SEMAPHORES;
   localparam int WAIT_SLOTS = csb_pkg::DEF_WAIT_DEPTH;
   localparam int TID_BITS   = csb_pkg::DEF_THREAD_ID_BITS;

   typedef struct {
      logic [2:0]  status;
      logic [15:0] count_value;
      logic        woken_valid;
      logic [7:0]  woken_thread;
   } sem_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_command;
   logic [3:0]  req_sem_index;
   logic [7:0]  req_caller_id;
   logic [15:0] req_init_value;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_count_value;
   logic        rsp_woken_valid;
   logic [7:0]  rsp_woken_thread;

   // predicted semaphore state
   bit          slot_live    [SEM_SLOTS];
   logic [15:0] slot_count   [SEM_SLOTS];
   logic [7:0]  slot_waiters [SEM_SLOTS][WAIT_SLOTS];
   int          slot_head    [SEM_SLOTS];
   int          slot_fill    [SEM_SLOTS];

   sem_result_type expected_results[$];
   int             mismatch_count = 0;
   int             hold_request = 0;
   bit             req_idle_on = 1'b1;
   bit             rsp_idle_on = 1'b1;

   counting_semaphore_bank dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_sem_index    (req_sem_index),
      .req_caller_id    (req_caller_id),
      .req_init_value   (req_init_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_count_value  (rsp_count_value),
      .rsp_woken_valid  (rsp_woken_valid),
      .rsp_woken_thread (rsp_woken_thread)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic sem_result_type predict_semaphore(input logic [2:0] cmd,
         input logic [3:0] idx, input logic [7:0] tid, input logic [15:0] ival);
      sem_result_type r;
      int c;
      int pos;
      r.status       = csb_pkg::ST_INVALID;
      r.count_value  = 16'd0;
      r.woken_valid  = 1'b0;
      r.woken_thread = 8'd0;
      if (cmd <= csb_pkg::CMD_RELEASE && idx < SEM_SLOTS &&
          (cmd == csb_pkg::CMD_INIT || slot_live[idx])) begin
         c = slot_count[idx];
         r.status = csb_pkg::ST_OK;
         case (cmd)
            csb_pkg::CMD_INIT: begin
               // re-init drops any queued waiters silently
               slot_live[idx] = 1'b1;
               slot_head[idx] = 0;
               slot_fill[idx] = 0;
               c = ival;
            end
            csb_pkg::CMD_WAIT: begin
               if (c != 0) begin
                  c--;
               end else if (slot_fill[idx] >= WAIT_SLOTS) begin
                  r.status = csb_pkg::ST_QFULL;
               end else begin
                  pos = (slot_head[idx] + slot_fill[idx]) % WAIT_SLOTS;
                  slot_waiters[idx][pos] = tid & 8'((1 << TID_BITS) - 1);
                  slot_fill[idx]++;
                  r.status = csb_pkg::ST_BLOCKED;
               end
            end
            csb_pkg::CMD_POST: begin
               if (c >= csb_pkg::COUNT_MAX) r.status = csb_pkg::ST_SATURATED;
               else c++;
               if (slot_fill[idx] != 0) begin
                  r.woken_valid  = 1'b1;
                  r.woken_thread = slot_waiters[idx][slot_head[idx]];
                  slot_head[idx] = (slot_head[idx] + 1) % WAIT_SLOTS;
                  slot_fill[idx]--;
               end
            end
            csb_pkg::CMD_TRYWAIT: begin
               if (c == 0) r.status = csb_pkg::ST_WOULD_BLOCK;
               else c--;
            end
            csb_pkg::CMD_GETVALUE: ;
            default: begin
               slot_live[idx] = 1'b0;
               slot_head[idx] = 0;
               slot_fill[idx] = 0;
               c = 0;
            end
         endcase
         slot_count[idx] = 16'(c);
         r.count_value = 16'(c);
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("ERROR at %0t: %s expected %0d got %0d", $time, what, want, got);
      mismatch_count++;
   endtask

   task automatic send_request(input logic [2:0] cmd, input logic [3:0] idx,
         input logic [7:0] tid, input logic [15:0] ival);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_sem_index  <= idx;
      req_caller_id  <= tid;
      req_init_value <= ival;
      do @(posedge clock); while (!(req_valid && !req_stall));
      expected_results.push_back(predict_semaphore(cmd, idx, tid, ival));
   endtask

   // receiver: random stall before each result, long hold when requested
   initial begin : result_receiver
      int gap;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_request != 0) begin
            gap = hold_request;
            hold_request = 0;
         end else begin
            gap = rsp_idle_on ? $urandom_range(0, 5) : 0;
         end
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall) && hold_request == 0);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : result_checker
      sem_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result transaction with nothing pending, status", -1, rsp_status);
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", want.status, rsp_status);
            if (rsp_count_value !== want.count_value)
               report_mismatch("count_value", want.count_value, rsp_count_value);
            if (rsp_woken_valid !== want.woken_valid)
               report_mismatch("woken_valid", want.woken_valid, rsp_woken_valid);
            if (rsp_woken_thread !== want.woken_thread)
               report_mismatch("woken_thread", want.woken_thread, rsp_woken_thread);
         end
      end
   end

   task automatic test_invalid_commands();
      send_request(csb_pkg::CMD_GETVALUE, 4'd7, 8'd1, 16'd0);
      send_request(csb_pkg::CMD_POST, 4'd7, 8'd2, 16'hFFFF);
      send_request(csb_pkg::CMD_RELEASE, 4'd7, 8'd3, 16'd0);
      // unknown opcodes
      send_request(3'd6, 4'd0, 8'd4, 16'h1234);
      send_request(3'd7, 4'd15, 8'hFF, 16'hFFFF);
   endtask

   task automatic test_init_and_trywait();
      send_request(csb_pkg::CMD_INIT, 4'd0, 8'd1, 16'd0);
      send_request(csb_pkg::CMD_TRYWAIT, 4'd0, 8'd1, 16'd0);
      send_request(csb_pkg::CMD_INIT, 4'd1, 8'd1, 16'hFFFF);
      send_request(csb_pkg::CMD_GETVALUE, 4'd1, 8'd1, 16'd0);
      send_request(csb_pkg::CMD_TRYWAIT, 4'd1, 8'd1, 16'd0);
   endtask

   task automatic test_wait_queue();
      send_request(csb_pkg::CMD_INIT, 4'd2, 8'd1, 16'd0);
      // zero and all-ones ids queue like any other
      send_request(csb_pkg::CMD_WAIT, 4'd2, 8'd0, 16'd0);
      send_request(csb_pkg::CMD_WAIT, 4'd2, 8'hFF, 16'd0);
      for (int i = 0; i < WAIT_SLOTS - 2; i++)
         send_request(csb_pkg::CMD_WAIT, 4'd2, 8'(8'h10 + i), 16'd0);
      send_request(csb_pkg::CMD_WAIT, 4'd2, 8'h55, 16'd0);
      send_request(csb_pkg::CMD_POST, 4'd2, 8'd1, 16'd0);
      send_request(csb_pkg::CMD_POST, 4'd2, 8'd1, 16'd0);
   endtask

   task automatic test_saturation_and_release();
      send_request(csb_pkg::CMD_POST, 4'd1, 8'd1, 16'd0);
      send_request(csb_pkg::CMD_POST, 4'd1, 8'd1, 16'd0);
      // re-init with waiters still queued, then a post must wake nobody
      send_request(csb_pkg::CMD_INIT, 4'd2, 8'd1, 16'd3);
      send_request(csb_pkg::CMD_POST, 4'd2, 8'd1, 16'd0);
      send_request(csb_pkg::CMD_WAIT, 4'd0, 8'd9, 16'd0);
      send_request(csb_pkg::CMD_RELEASE, 4'd0, 8'd1, 16'd0);
      send_request(csb_pkg::CMD_GETVALUE, 4'd0, 8'd1, 16'd0);
   endtask

   task automatic test_backpressure();
      req_idle_on  = 1'b0;
      hold_request = 40;
      for (int i = 0; i < 24; i++)
         send_request(csb_pkg::CMD_GETVALUE, 4'(i % 4), 8'd1, 16'd0);
      req_idle_on = 1'b1;
   endtask

   task automatic test_random_traffic(input int n_items);
      int          roll;
      logic [2:0]  cmd;
      logic [3:0]  idx;
      logic [7:0]  tid;
      logic [15:0] ival;
      for (int i = 0; i < n_items; i++) begin
         // alternate phases: no idling, sender idling only, both idling
         case ((i / 100) % 3)
            0: begin
               req_idle_on = 1'b0;
               rsp_idle_on = 1'b0;
            end
            1: begin
               req_idle_on = 1'b1;
               rsp_idle_on = 1'b0;
            end
            default: begin
               req_idle_on = 1'b1;
               rsp_idle_on = 1'b1;
            end
         endcase
         roll = $urandom_range(0, 99);
         if (roll < 12)      cmd = csb_pkg::CMD_INIT;
         else if (roll < 40) cmd = csb_pkg::CMD_WAIT;
         else if (roll < 65) cmd = csb_pkg::CMD_POST;
         else if (roll < 75) cmd = csb_pkg::CMD_TRYWAIT;
         else if (roll < 87) cmd = csb_pkg::CMD_GETVALUE;
         else if (roll < 95) cmd = csb_pkg::CMD_RELEASE;
         else                cmd = 3'($urandom_range(6, 7));
         // concentrate on a few slots so queues get deep
         if ($urandom_range(0, 9) < 7) idx = 4'($urandom_range(0, 3));
         else                          idx = 4'($urandom_range(0, SEM_SLOTS - 1));
         tid = 8'($urandom_range(1, 255));
         case ($urandom_range(0, 7))
            0, 1, 2, 3: ival = 16'($urandom_range(0, 3));
            4:          ival = csb_pkg::COUNT_MAX;
            5:          ival = csb_pkg::COUNT_MAX - 16'd1;
            default:    ival = 16'($urandom_range(0, 65535));
         endcase
         send_request(cmd, idx, tid, ival);
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_command    = csb_pkg::CMD_GETVALUE;
      req_sem_index  = 4'd0;
      req_caller_id  = 8'd0;
      req_init_value = 16'd0;
      for (int s = 0; s < SEM_SLOTS; s++) begin
         slot_live[s]  = 1'b0;
         slot_count[s] = 16'd0;
         slot_head[s]  = 0;
         slot_fill[s]  = 0;
      end
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_invalid_commands();
      test_init_and_trywait();
      test_wait_queue();
      test_saturation_and_release();
      test_backpressure();
      test_random_traffic(700);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
